// File: src/eott_pkg.sv
`timescale 1ns / 1ps
package eott_pkg;

	localparam int ID_W        = 4;
	localparam int EXT_TIME_W  = 32;
	localparam int STAMP_W     = 32;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EXPIRED   = 2'd2,
		ST_NONE      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ID_CMD     = 2'd0,
		ID_PENDING = 2'd1,
		ID_ZERO    = 2'd2
	} id_sel_t;

	typedef struct packed {
		logic    load;
		logic    arm;
		logic    free_cmd;
		logic    scan_clear;
		logic    scan_step;
		logic    free_best;
		logic    take_best;
		logic    emit;
		status_t emit_status;
		id_sel_t emit_id;
		logic    emit_last;
	} eott_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic id_ok;
		logic id_active;
		logic scan_end;
		logic best_vld;
		logic out_free;
	} eott_stat_t;

endpackage

// File: src/eott_req_if.sv
`timescale 1ns / 1ps
interface eott_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  timer_id;
	logic [31:0] expire_time;
	logic [31:0] now;

	modport source (output valid, output cmd, output timer_id, output expire_time,
		output now, input ready);
	modport sink (input valid, input cmd, input timer_id, input expire_time,
		input now, output ready);
endinterface

// File: src/eott_rsp_if.sv
`timescale 1ns / 1ps
interface eott_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] expired_id;
	logic       last;

	modport source (output valid, output status, output expired_id, output last,
		input ready);
	modport sink (input valid, input status, input expired_id, input last,
		output ready);
endinterface

// File: src/eott_ctrl.sv
`timescale 1ns / 1ps
module eott_ctrl import eott_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  eott_stat_t st,
	output logic       ready,
	output eott_ctrl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_FINAL
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_vld_q;
	logic             cnt_full;

	assign ready    = (state_q == S_IDLE);
	assign cnt_full = (cnt_q == CNT_W'(MAX_RESULTS - 1));

	always_comb begin
		ctl             = '0;
		ctl.emit_status = ST_DONE;
		ctl.emit_id     = ID_CMD;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = accept;
			end
			S_EXEC: begin
				if (st.cmd == CMD_TICK) begin
					ctl.scan_clear = 1'b1;
				end else if (st.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_last = 1'b1;
					if (!st.id_ok) begin
						ctl.emit_status = ST_NOT_FOUND;
					end else if (st.cmd == CMD_ADD) begin
						ctl.arm = 1'b1;
					end else if (!st.id_active) begin
						ctl.emit_status = ST_NOT_FOUND;
					end else if (st.cmd == CMD_ADJUST) begin
						ctl.arm = 1'b1;
					end else begin
						ctl.free_cmd = 1'b1;
					end
				end
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
			end
			S_DRAIN: begin
			end
			S_DECIDE: begin
				if (st.out_free) begin
					if (st.best_vld) begin
						ctl.free_best = 1'b1;
						ctl.take_best = 1'b1;
						ctl.scan_clear = !cnt_full;
						if (pend_vld_q) begin
							ctl.emit        = 1'b1;
							ctl.emit_status = ST_EXPIRED;
							ctl.emit_id     = ID_PENDING;
						end
					end else begin
						ctl.emit      = 1'b1;
						ctl.emit_last = 1'b1;
						if (pend_vld_q) begin
							ctl.emit_status = ST_EXPIRED;
							ctl.emit_id     = ID_PENDING;
						end else begin
							ctl.emit_status = ST_NONE;
							ctl.emit_id     = ID_ZERO;
						end
					end
				end
			end
			S_FINAL: begin
				if (st.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_last   = 1'b1;
					ctl.emit_status = ST_EXPIRED;
					ctl.emit_id     = ID_PENDING;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (st.cmd == CMD_TICK) begin
						state_q    <= S_SCAN;
						cnt_q      <= '0;
						pend_vld_q <= 1'b0;
					end else if (st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (st.scan_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (st.out_free) begin
						if (st.best_vld) begin
							pend_vld_q <= 1'b1;
							cnt_q      <= cnt_q + 1'b1;
							state_q    <= cnt_full ? S_FINAL : S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FINAL: begin
					if (st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/eott_dp.sv
`timescale 1ns / 1ps
module eott_dp import eott_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  eott_ctrl_t            ctl,
	output eott_stat_t            st,
	input  logic [1:0]            cmd,
	input  logic [ID_W-1:0]       timer_id,
	input  logic [EXT_TIME_W-1:0] expire_time,
	input  logic [EXT_TIME_W-1:0] now,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [ID_W-1:0]       expired_id,
	output logic                  last
);

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	cmd_t                 cmd_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [TIME_BITS-1:0] now_q;
	logic [63:0]          exp_wide;
	logic [63:0]          now_wide;
	logic [7:0]           id_wide;
	logic [SLOT_W-1:0]    slot_id;

	logic [TIMER_SLOTS-1:0] active_q;
	logic [TIME_BITS-1:0]   exp_mem   [TIMER_SLOTS];
	logic [STAMP_W-1:0]     stamp_mem [TIMER_SLOTS];
	logic [STAMP_W-1:0]     next_stamp_q;

	logic [SLOT_W-1:0]    scan_q;
	logic                 rd_vld_s1;
	logic                 act_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic [TIME_BITS-1:0] exp_s1;
	logic [STAMP_W-1:0]   stamp_s1;

	logic                 best_vld_q;
	logic [SLOT_W-1:0]    best_idx_q;
	logic [TIME_BITS-1:0] best_exp_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic                 better;

	logic [SLOT_W-1:0] pend_q;
	logic [7:0]        pend_wide;

	logic              out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   id_out_q;
	logic              last_q;

	assign exp_wide  = {32'b0, expire_time};
	assign now_wide  = {32'b0, now};
	assign id_wide   = {4'b0, id_q};
	assign slot_id   = id_wide[SLOT_W-1:0];
	assign pend_wide = 8'(pend_q);

	assign st.cmd       = cmd_q;
	assign st.id_ok     = (32'(id_q) < TIMER_SLOTS);
	assign st.id_active = st.id_ok && active_q[slot_id];
	assign st.scan_end  = (scan_q == SLOT_W'(TIMER_SLOTS - 1));
	assign st.best_vld  = best_vld_q;
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign expired_id = id_out_q;
	assign last       = last_q;

	// command word
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(cmd);
			id_q  <= timer_id;
			exp_q <= exp_wide[TIME_BITS-1:0];
			now_q <= now_wide[TIME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			next_stamp_q <= '0;
		end else begin
			if (ctl.arm) begin
				active_q[slot_id] <= 1'b1;
				next_stamp_q      <= next_stamp_q + 1'b1;
			end else if (ctl.free_cmd) begin
				active_q[slot_id] <= 1'b0;
			end
			if (ctl.free_best) begin
				active_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.arm) begin
			exp_mem[slot_id]   <= exp_q;
			stamp_mem[slot_id] <= next_stamp_q;
		end
	end

	always_ff @(posedge clk) begin
		exp_s1   <= exp_mem[scan_q];
		stamp_s1 <= stamp_mem[scan_q];
		act_s1   <= active_q[scan_q];
		idx_s1   <= scan_q;
	end

	assign better = rd_vld_s1 && act_s1 && (exp_s1 <= now_q) &&
		(!best_vld_q || (exp_s1 < best_exp_q) ||
		((exp_s1 == best_exp_q) && (stamp_s1 < best_stamp_q)));

	// scan for the earliest due slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.scan_step;
			if (ctl.scan_clear) begin
				scan_q     <= '0;
				best_vld_q <= 1'b0;
			end else begin
				if (ctl.scan_step) begin
					scan_q <= scan_q + 1'b1;
				end
				if (better) begin
					best_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_idx_q   <= idx_s1;
			best_exp_q   <= exp_s1;
			best_stamp_q <= stamp_s1;
		end
		if (ctl.take_best) begin
			pend_q <= best_idx_q;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			status_q <= ctl.emit_status;
			last_q   <= ctl.emit_last;
			case (ctl.emit_id)
				ID_CMD:     id_out_q <= id_q;
				ID_PENDING: id_out_q <= pend_wide[ID_W-1:0];
				default:    id_out_q <= '0;
			endcase
		end
	end

endmodule

// File: src/expiry_ordered_timer_table_core.sv
`timescale 1ns / 1ps
// Timer table of TIMER_SLOTS slots addressed by timer id. Add, adjust and delete
// each give one result word; the command word is registered first, and the result
// word is registered from the execute state once the result side is free. A tick
// scans every slot once per expired timer it reports, and once more when fewer than
// sixteen are due, through a single read port on the expiry and stamp stores, picking
// the earliest due timer (ties by arming order). With sixteen or more due it reports
// the first sixteen and the rest stay armed. A stalled result side stalls the table.
// One command is worked at a time; the next command word is taken while the last
// result word still waits.
module expiry_ordered_timer_table_core import eott_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 32
) (
	input logic         clk,
	input logic         arst_n,
	eott_req_if.sink    req,
	eott_rsp_if.source  rsp
);

	eott_ctrl_t ctl;
	eott_stat_t st;
	logic       ready;
	logic       accept;

	assign req.ready = ready;
	assign accept    = req.valid && ready;

	eott_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.st     (st),
		.ready  (ready),
		.ctl    (ctl)
	);

	eott_dp #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.st          (st),
		.cmd         (req.cmd),
		.timer_id    (req.timer_id),
		.expire_time (req.expire_time),
		.now         (req.now),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.status      (rsp.status),
		.expired_id  (rsp.expired_id),
		.last        (rsp.last)
	);

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!rsp.valid || rsp.ready))
		else $error("result word loaded over a waiting word");

	a_free_best: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.free_best |-> st.best_vld)
		else $error("slot freed without a chosen timer");

	a_arm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.arm || ctl.free_cmd) |-> st.id_ok)
		else $error("slot update for id beyond the table");

	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> !req.ready || rsp.last || !rsp.valid || rsp.ready)
		else $error("command taken before the final word");
`endif

endmodule

// File: test/tb_expiry_ordered_timer_table_core.sv
`timescale 1ns / 1ps
module tb_expiry_ordered_timer_table_core;
	import eott_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [3:0] id;
		logic       last;
	} rsp_word_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  id;
		logic [31:0] expire_time;
		logic [31:0] now;
		logic        typed;
		status_t     status;
		logic [3:0]  rsp_id;
	} script_row_t;

	localparam int SCRIPT_LEN = 22;
	localparam int RANDOM_ITEMS = 128;

	logic clk;
	logic arst_n;

	eott_req_if req_ch ();
	eott_rsp_if rsp_ch ();

	expiry_ordered_timer_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// own view of the timer table
	bit          tt_active [16];
	logic [31:0] tt_expiry [16];
	logic [31:0] tt_stamp [16];
	logic [31:0] tt_next_stamp;

	rsp_word_t pending_words [$];
	rsp_word_t step_words [$];
	int        fails;
	int        items_sent;
	bit        req_calm;
	bit        rsp_calm;
	logic [31:0] wall;

	// typed expectations hold for a single word with last set
	script_row_t script [SCRIPT_LEN] = '{
		'{CMD_TICK,   4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_NONE,      4'd0},
		'{CMD_ADJUST, 4'd5,  32'h0000_0010, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 4'd5},
		'{CMD_DELETE, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 4'd15},
		'{CMD_ADD,    4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_DONE,      4'd0},
		'{CMD_ADD,    4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE,      4'd15},
		'{CMD_ADD,    4'd3,  32'd100,       32'h0000_0000, 1'b1, ST_DONE,      4'd3},
		'{CMD_ADD,    4'd4,  32'd100,       32'h0000_0000, 1'b1, ST_DONE,      4'd4},
		'{CMD_ADD,    4'd3,  32'd100,       32'h0000_0000, 1'b1, ST_DONE,      4'd3},
		'{CMD_ADJUST, 4'd15, 32'd50,        32'h0000_0000, 1'b1, ST_DONE,      4'd15},
		'{CMD_TICK,   4'd9,  32'hAAAA_5555, 32'h0000_0000, 1'b0, ST_DONE,      4'd0},
		'{CMD_TICK,   4'd6,  32'h5555_AAAA, 32'd99,        1'b0, ST_DONE,      4'd0},
		'{CMD_TICK,   4'd0,  32'h0000_0000, 32'd100,       1'b0, ST_DONE,      4'd0},
		'{CMD_DELETE, 4'd3,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 4'd3},
		'{CMD_ADD,    4'd7,  32'hFFFF_FFFF, 32'h5555_AAAA, 1'b1, ST_DONE,      4'd7},
		'{CMD_ADD,    4'd8,  32'h8000_0000, 32'h0000_0000, 1'b1, ST_DONE,      4'd8},
		'{CMD_DELETE, 4'd8,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE,      4'd8},
		'{CMD_ADJUST, 4'd7,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_DONE,      4'd7},
		'{CMD_ADD,    4'd1,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE,      4'd1},
		'{CMD_ADD,    4'd10, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE,      4'd10},
		'{CMD_TICK,   4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b0, ST_DONE,      4'd0},
		'{CMD_TICK,   4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_DONE,      4'd0},
		'{CMD_TICK,   4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_NONE,      4'd0}
	};

	function automatic void queue_step(input rsp_word_t w);
		step_words.insert(step_words.size(), w);
	endfunction

	function automatic void queue_pending(input rsp_word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic void arm_timer(input logic [3:0] id, input logic [31:0] et);
		tt_active[id] = 1'b1;
		tt_expiry[id] = et;
		tt_stamp[id] = tt_next_stamp;
		tt_next_stamp = tt_next_stamp + 32'd1;
	endfunction

	// works out the words one command gives, into step_words
	function automatic void timer_table_apply(input cmd_t c, input logic [3:0] id,
		input logic [31:0] et, input logic [31:0] nw);
		int best;
		step_words.delete();
		case (c)
			CMD_TICK: begin
				while (step_words.size() < MAX_RESULTS) begin
					best = -1;
					for (int i = 0; i < 16; i++) begin
						if (tt_active[i] && tt_expiry[i] <= nw) begin
							if (best < 0 || tt_expiry[i] < tt_expiry[best] ||
								(tt_expiry[i] == tt_expiry[best] && tt_stamp[i] < tt_stamp[best]))
								best = i;
						end
					end
					if (best < 0)
						break;
					tt_active[best] = 1'b0;
					queue_step('{ST_EXPIRED, best[3:0], 1'b0});
				end
				if (step_words.size() == 0)
					queue_step('{ST_NONE, 4'd0, 1'b1});
				else
					step_words[step_words.size() - 1].last = 1'b1;
			end
			CMD_ADD: begin
				arm_timer(id, et);
				queue_step('{ST_DONE, id, 1'b1});
			end
			default: begin
				if (!tt_active[id]) begin
					queue_step('{ST_NOT_FOUND, id, 1'b1});
				end else begin
					if (c == CMD_ADJUST)
						arm_timer(id, et);
					else
						tt_active[id] = 1'b0;
					queue_step('{ST_DONE, id, 1'b1});
				end
			end
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic send_word(input cmd_t c, input logic [3:0] id, input logic [31:0] et,
		input logic [31:0] nw, input bit typed, input rsp_word_t want);
		int gap;
		gap = req_calm ? 0 : idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.timer_id <= id;
		req_ch.expire_time <= et;
		req_ch.now <= nw;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		timer_table_apply(c, id, et, nw);
		if (typed)
			queue_pending(want);
		else
			foreach (step_words[k])
				queue_pending(step_words[k]);
		items_sent++;
	endtask

	task automatic random_op();
		int r;
		int live [$];
		cmd_t c;
		logic [3:0] id;
		logic [31:0] et;
		logic [31:0] nw;
		r = $urandom_range(0, 99);
		c = (r < 40) ? CMD_ADD : (r < 55) ? CMD_ADJUST : (r < 70) ? CMD_DELETE : CMD_TICK;
		for (int i = 0; i < 16; i++)
			if (tt_active[i])
				live.insert(live.size(), i);
		id = 4'($urandom_range(0, 15));
		if ((c == CMD_ADJUST || c == CMD_DELETE) && live.size() > 0 &&
			$urandom_range(0, 3) != 0)
			id = 4'(live[$urandom_range(0, live.size() - 1)]);
		et = ($urandom_range(0, 9) == 0) ? $urandom : wall + $urandom_range(0, 24);
		nw = $urandom;
		if (c == CMD_TICK && $urandom_range(0, 11) != 0) begin
			nw = wall + $urandom_range(0, 12);
			wall = nw;
		end
		send_word(c, id, et, nw, 1'b0, '0);
	endtask

	// arm every slot close together, then let them all fall due at once
	task automatic fill_burst();
		int order [16];
		int j;
		int t;
		for (int i = 0; i < 16; i++)
			order[i] = i;
		for (int i = 15; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < 16; i++)
			send_word(CMD_ADD, order[i][3:0], wall + $urandom_range(0, 3), $urandom, 1'b0, '0);
		wall = wall + 32'd3 + $urandom_range(0, 2);
		send_word(CMD_TICK, 4'($urandom_range(0, 15)), $urandom, wall, 1'b0, '0);
	endtask

	task automatic check_word();
		rsp_word_t want;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected word status %0d id %0d last %0d", $time,
				rsp_ch.status, rsp_ch.expired_id, rsp_ch.last);
			fails++;
		end else begin
			want = pending_words.pop_front();
			if (rsp_ch.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status,
					rsp_ch.status);
				fails++;
			end
			if (rsp_ch.expired_id !== want.id) begin
				$display("%0t: expired_id expected %0d actual %0d", $time, want.id,
					rsp_ch.expired_id);
				fails++;
			end
			if (rsp_ch.last !== want.last) begin
				$display("%0t: last expected %0d actual %0d", $time, want.last,
					rsp_ch.last);
				fails++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// result side with random stalls
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				check_word();
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!rsp_calm && $urandom_range(0, 2) == 0)
					hold = idle_len();
			end
		end
	end

	initial begin
		int r;
		int n;
		fails = 0;
		items_sent = 0;
		req_calm = 1'b0;
		rsp_calm = 1'b0;
		wall = 32'd1000;
		tt_next_stamp = '0;
		for (int i = 0; i < 16; i++)
			tt_active[i] = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_ADD;
		req_ch.timer_id <= '0;
		req_ch.expire_time <= '0;
		req_ch.now <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_word(script[i].cmd, script[i].id, script[i].expire_time, script[i].now,
				script[i].typed, '{script[i].status, script[i].rsp_id, 1'b1});

		while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
			req_calm = ($urandom_range(0, 5) == 0);
			rsp_calm = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				fill_burst();
			end else if (r < 88) begin
				n = $urandom_range(1, 6);
				repeat (n) random_op();
			end else begin
				// noise: every field at random
				n = $urandom_range(1, 3);
				repeat (n)
					send_word(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
						$urandom, $urandom, 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
